[hw/rtl/fhbp_pkg.sv]
package fhbp_pkg;

  localparam int MaxDet = 32;
  localparam int IdxW = 5;
  localparam int CntW = 6;

  localparam logic [1:0] ClassDeleted = 2'd0;
  localparam logic [1:0] ClassHead = 2'd1;
  localparam logic [1:0] ClassFace = 2'd2;

  localparam logic [0:0] RegIouThreshold = 1'd0;
  localparam logic [0:0] RegKeepScore = 1'd1;

  localparam logic [15:0] IouThresholdReset = 16'd1966;
  localparam logic [15:0] KeepScoreReset = 16'd58982;

  typedef struct packed {
    logic [7:0] tag;
    logic [1:0] class_id;
    logic [15:0] score;
    logic [15:0] box_x1;
    logic [15:0] box_y1;
    logic [15:0] box_x2;
    logic [15:0] box_y2;
    logic last_in;
  } det_in_t;

  typedef struct packed {
    logic [7:0] out_tag;
    logic [1:0] out_class;
    logic [15:0] out_score;
    logic [15:0] out_x1;
    logic [15:0] out_y1;
    logic [15:0] out_x2;
    logic [15:0] out_y2;
    logic last_out;
    logic [6:0] total_count;
    logic overflow;
  } det_out_t;

  // Stored record: tag, class, score and box coordinates x1, y1, x2, y2.
  localparam int RecW = 8 + 2 + 16 + 64;

  typedef struct packed {
    logic start;
    logic [31:0] inter;
    logic [32:0] uni;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [16:0] quot;
  } div_rsp_t;

endpackage

[hw/rtl/fhbp_ram.sv]
module fhbp_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/fhbp_div.sv]
module fhbp_div (
  input  logic                  clk,
  input  logic                  rst,
  input  fhbp_pkg::div_req_t    req,
  output fhbp_pkg::div_rsp_t    rsp
);
  import fhbp_pkg::*;

  // Restoring division of inter << 16 by uni, one quotient bit a cycle.
  // The caller guarantees inter < uni, so the remainder starts out as inter
  // and only the 16 fraction bits of the quotient need trial subtractions.
  logic [32:0] divisor;
  logic [32:0] rem;
  logic [15:0] quot;
  logic [3:0] step;
  logic busy;
  logic finished;
  logic [33:0] shifted;
  logic [34:0] trial;

  assign shifted = {rem, 1'b0};
  assign trial = {1'b0, shifted} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      finished <= 1'b0;
    end else begin
      finished <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 4'd0;
        divisor <= req.uni;
        rem <= {1'b0, req.inter};
        quot <= 16'd0;
      end else if (busy) begin
        if (!trial[34]) begin
          rem <= trial[32:0];
          quot <= {quot[14:0], 1'b1};
        end else begin
          rem <= shifted[32:0];
          quot <= {quot[14:0], 1'b0};
        end
        step <= step + 4'd1;
        if (step == 4'd15) begin
          busy <= 1'b0;
          finished <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: finished, quot: {1'b0, quot}};
endmodule

[hw/rtl/face_head_box_pairing_core.sv]
// Pairing core for one frame of face and head detections. Detections are
// loaded one per cycle while busy is low; the request carrying last_in
// starts the pairing pass, which holds busy high. For each face the pass
// visits every head in turn through one shared IoU datapath: a fetch,
// subtraction, multiplication and union stages and a 16-step quotient
// unit. A face-head pair needs the division unless the boxes do not
// overlap or the overlap is the union; a head already claimed is skipped.
// Then every record is emitted. Results leave one per strobe and cannot
// be stalled by the receiver. Storage is a set of 32-entry RAMs with
// registered read; stores need no clearing.
module face_head_box_pairing_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  fhbp_pkg::det_in_t    request,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data,
  output logic                 result_valid,
  output fhbp_pkg::det_out_t   result
);
  import fhbp_pkg::*;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SFace  = 4'd1;
  localparam logic [3:0] SRdF   = 4'd2;
  localparam logic [3:0] SRdH   = 4'd3;
  localparam logic [3:0] SGeo   = 4'd4;
  localparam logic [3:0] SMul   = 4'd5;
  localparam logic [3:0] SUni   = 4'd6;
  localparam logic [3:0] SDiv   = 4'd7;
  localparam logic [3:0] SCmp   = 4'd8;
  localparam logic [3:0] SDecide = 4'd9;
  localparam logic [3:0] SEmit  = 4'd10;
  localparam logic [3:0] SEmRd  = 4'd11;
  localparam logic [3:0] SEmOut = 4'd12;
  localparam logic [3:0] SWait  = 4'd13;

  localparam logic [1:0] PhFaces = 2'd0;
  localparam logic [1:0] PhPairs = 2'd1;
  localparam logic [1:0] PhHeads = 2'd2;

  logic [15:0] iou_threshold;
  logic [15:0] keep_score;
  logic [3:0] state;
  logic [CntW-1:0] item_count;
  logic [CntW-1:0] face_count;
  logic drop_flag;
  logic [MaxDet-1:0] head_claimed;
  logic [MaxDet-1:0] deleted;
  logic [CntW-1:0] np;
  logic [6:0] total;
  logic [6:0] emitted;

  logic [CntW-1:0] f_idx;
  logic [CntW-1:0] h_idx;
  logic [CntW-1:0] best;
  logic [16:0] best_v;
  logic [15:0] face_score;
  logic [63:0] face_box;

  logic [1:0] phase;
  logic [CntW-1:0] e_idx;

  // Record RAM, pair list RAM.
  logic rec_we;
  logic [IdxW-1:0] rec_waddr;
  logic [RecW-1:0] rec_wdata;
  logic [IdxW-1:0] rec_raddr;
  logic [RecW-1:0] rec_rdata;
  logic pair_we;
  logic [IdxW-1:0] pair_waddr;
  logic [CntW-1:0] pair_wdata;
  logic [IdxW-1:0] pair_raddr;
  logic [CntW-1:0] pair_rdata;

  fhbp_ram #(.Width(RecW), .Depth(MaxDet)) u_rec (
    .clk, .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(rec_raddr), .rdata(rec_rdata)
  );
  fhbp_ram #(.Width(CntW), .Depth(MaxDet)) u_pair (
    .clk, .we(pair_we), .waddr(pair_waddr), .wdata(pair_wdata),
    .raddr(pair_raddr), .rdata(pair_rdata)
  );

  logic [15:0] rx1, ry1, rx2, ry2;
  assign rx1 = rec_rdata[63:48];
  assign ry1 = rec_rdata[47:32];
  assign rx2 = rec_rdata[31:16];
  assign ry2 = rec_rdata[15:0];

  // IoU datapath registers.
  logic signed [16:0] ix, iy, fw, fh, hw, hh;
  logic ix_ok, iy_ok;
  logic signed [33:0] inter, area_f, area_h;
  logic signed [35:0] uni;
  logic [16:0] iou;

  logic div_start;
  div_req_t dreq;
  div_rsp_t drsp;
  fhbp_div u_div (.clk, .rst, .req(dreq), .rsp(drsp));

  logic accept;
  assign accept = start && !busy;
  assign busy = (state != SIdle);

  logic [15:0] fx1, fy1, fx2, fy2;
  assign fx1 = face_box[63:48];
  assign fy1 = face_box[47:32];
  assign fx2 = face_box[31:16];
  assign fy2 = face_box[15:0];

  logic [15:0] mx2, my2, mx1, my1;
  assign mx2 = (fx2 < rx2) ? fx2 : rx2;
  assign mx1 = (fx1 > rx1) ? fx1 : rx1;
  assign my2 = (fy2 < ry2) ? fy2 : ry2;
  assign my1 = (fy1 > ry1) ? fy1 : ry1;

  // Record read address follows the sequencer.
  always_comb begin
    rec_raddr = h_idx[IdxW-1:0];
    unique case (state)
      SFace: rec_raddr = f_idx[IdxW-1:0];
      SEmit, SEmRd: begin
        if (phase == PhPairs) begin
          rec_raddr = pair_rdata[IdxW-1:0];
        end else begin
          rec_raddr = e_idx[IdxW-1:0];
        end
      end
      default: rec_raddr = h_idx[IdxW-1:0];
    endcase
  end

  assign rec_we = accept && (item_count < CntW'(MaxDet));
  assign rec_waddr = item_count[IdxW-1:0];
  assign rec_wdata = {request.tag, request.class_id, request.score, request.box_x1,
                      request.box_y1, request.box_x2, request.box_y2};

  assign pair_raddr = e_idx[IdxW-1:0];
  assign dreq = '{start: div_start, inter: inter[31:0], uni: uni[32:0]};

  logic [15:0] r_score;
  logic [1:0] r_class;
  assign r_score = rec_rdata[79:64];
  assign r_class = rec_rdata[81:80];

  logic face_match;
  assign face_match = (best != item_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      iou_threshold <= IouThresholdReset;
      keep_score <= KeepScoreReset;
      state <= SIdle;
      item_count <= '0;
      face_count <= '0;
      drop_flag <= 1'b0;
      head_claimed <= '0;
      result_valid <= 1'b0;
      pair_we <= 1'b0;
      div_start <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      pair_we <= 1'b0;
      div_start <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          RegIouThreshold: iou_threshold <= cfg_data;
          RegKeepScore: keep_score <= cfg_data;
        endcase
      end
      unique case (state)
        SIdle: begin
          if (accept) begin
            logic [CntW-1:0] n_items;
            logic [CntW-1:0] n_faces;
            n_items = item_count;
            n_faces = face_count;
            if (item_count < CntW'(MaxDet)) begin
              if (face_count == item_count && request.class_id[1]) begin
                n_faces = face_count + 1'b1;
              end
              n_items = item_count + 1'b1;
            end else begin
              drop_flag <= 1'b1;
            end
            item_count <= n_items;
            face_count <= n_faces;
            if (request.last_in) begin
              head_claimed <= '0;
              deleted <= '0;
              np <= '0;
              f_idx <= '0;
              total <= 7'(n_items);
              state <= SFace;
            end
          end
        end
        SFace: begin
          if (f_idx == face_count) begin
            phase <= PhFaces;
            e_idx <= '0;
            emitted <= '0;
            state <= SEmit;
          end else begin
            best <= item_count;
            best_v <= '0;
            h_idx <= face_count;
            state <= SRdF;
          end
        end
        SRdF: begin
          // Face record is on the read port on the first visit of a scan.
          if (h_idx == face_count) begin
            face_box <= rec_rdata[63:0];
            face_score <= r_score;
          end
          state <= SRdH;
        end
        SRdH: begin
          if (h_idx == item_count) begin
            state <= SDecide;
          end else if (head_claimed[h_idx[IdxW-1:0]]) begin
            h_idx <= h_idx + 1'b1;
            state <= SRdF;
          end else begin
            state <= SGeo;
          end
        end
        SGeo: begin
          ix <= $signed({1'b0, mx2}) - $signed({1'b0, mx1});
          iy <= $signed({1'b0, my2}) - $signed({1'b0, my1});
          fw <= $signed({1'b0, fx2}) - $signed({1'b0, fx1});
          fh <= $signed({1'b0, fy2}) - $signed({1'b0, fy1});
          hw <= $signed({1'b0, rx2}) - $signed({1'b0, rx1});
          hh <= $signed({1'b0, ry2}) - $signed({1'b0, ry1});
          state <= SMul;
        end
        SMul: begin
          ix_ok <= ix > 0;
          iy_ok <= iy > 0;
          inter <= ix * iy;
          area_f <= fw * fh;
          area_h <= hw * hh;
          state <= SUni;
        end
        SUni: begin
          uni <= 36'(area_f) + 36'(area_h) - 36'(inter);
          state <= SDiv;
        end
        SDiv: begin
          if (!ix_ok || !iy_ok || uni <= 0) begin
            iou <= '0;
            state <= SCmp;
          end else if (36'(inter) >= uni) begin
            iou <= 17'h10000;
            state <= SCmp;
          end else begin
            div_start <= 1'b1;
            state <= SWait;
          end
        end
        SWait: begin
          if (drsp.done) begin
            iou <= drsp.quot;
            state <= SCmp;
          end
        end
        SCmp: begin
          if (iou > {1'b0, iou_threshold} && iou > best_v) begin
            best <= h_idx;
            best_v <= iou;
          end
          h_idx <= h_idx + 1'b1;
          state <= SRdF;
        end
        SDecide: begin
          if (face_match) begin
            head_claimed[best[IdxW-1:0]] <= 1'b1;
            pair_we <= 1'b1;
            pair_waddr <= np[IdxW-1:0];
            pair_wdata <= best;
            np <= np + 1'b1;
            total <= total + 7'd0;
          end else if (face_score <= keep_score) begin
            deleted[f_idx[IdxW-1:0]] <= 1'b1;
          end else begin
            pair_we <= 1'b1;
            pair_waddr <= np[IdxW-1:0];
            pair_wdata <= f_idx;
            np <= np + 1'b1;
            total <= total + 7'd1;
          end
          f_idx <= f_idx + 1'b1;
          state <= SFace;
        end
        SEmit: begin
          priority if (phase == PhFaces && e_idx == face_count) begin
            phase <= PhPairs;
            e_idx <= '0;
          end else if (phase == PhPairs && e_idx == np) begin
            phase <= PhHeads;
            e_idx <= face_count;
          end else if (phase == PhHeads && e_idx == item_count) begin
            item_count <= '0;
            face_count <= '0;
            drop_flag <= 1'b0;
            head_claimed <= '0;
            state <= SIdle;
          end else if (phase == PhHeads && head_claimed[e_idx[IdxW-1:0]]) begin
            e_idx <= e_idx + 1'b1;
          end else begin
            state <= SEmRd;
          end
        end
        SEmRd: begin
          state <= SEmOut;
        end
        SEmOut: begin
          logic [1:0] cls;
          cls = r_class;
          if (phase == PhFaces && deleted[e_idx[IdxW-1:0]]) begin
            cls = ClassDeleted;
          end else if (phase == PhPairs && pair_rdata < face_count) begin
            cls = ClassHead;
          end
          result_valid <= 1'b1;
          result.out_tag <= rec_rdata[89:82];
          result.out_class <= cls;
          result.out_score <= r_score;
          result.out_x1 <= rx1;
          result.out_y1 <= ry1;
          result.out_x2 <= rx2;
          result.out_y2 <= ry2;
          result.last_out <= (emitted + 7'd1 == total);
          result.total_count <= total;
          result.overflow <= drop_flag;
          emitted <= emitted + 7'd1;
          e_idx <= e_idx + 1'b1;
          state <= SEmit;
        end
        default: state <= SIdle;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !(rec_we)) else $error("record written while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    face_count <= item_count) else $error("face count exceeds items");
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy)) else $error("result outside pairing pass");
endmodule
